[rtl/ultrasonic_echo_ranger_macros.svh]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared property forms for the checker, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ultrasonic echo ranger: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ultrasonic echo ranger: assertion failed");

`endif

[rtl/uer_pkg.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Types, widths, register indexes and reset values shared by the ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  parameter int unsigned CountWidthDef = 24;
  parameter int unsigned PhaseCntW     = 24;
  parameter int unsigned DistW         = 14;
  parameter int unsigned ScaleW        = 32;
  parameter int unsigned RangeW        = 10;
  parameter int unsigned FracBits      = 4;
  parameter int unsigned ProdShift     = 28;
  parameter int unsigned CfgIdxW       = 4;
  parameter int unsigned CfgDataW      = 32;

  parameter logic [DistW-1:0] DistMax = '1;

  parameter logic [15:0]          PreLowRst   = 16'd160;
  parameter logic [15:0]          PulseRst    = 16'd96;
  parameter logic [15:0]          PostLowRst  = 16'd160;
  parameter logic [23:0]          IntervalRst = 24'd1600000;
  parameter logic [23:0]          TimeoutRst  = 24'd16000000;
  parameter logic [ScaleW-1:0]    ScaleRst    = 32'd9133826;
  parameter logic [RangeW-1:0]    MaxRangeRst = 10'd500;
  parameter logic [RangeW-1:0]    NearRst     = 10'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRE_LOW  = 4'd0,
    CFG_PULSE    = 4'd1,
    CFG_POST_LOW = 4'd2,
    CFG_INTERVAL = 4'd3,
    CFG_TIMEOUT  = 4'd4,
    CFG_SCALE    = 4'd5,
    CFG_MAX_RNG  = 4'd6,
    CFG_NEAR     = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_PRE   = 3'd0,
    PH_PULSE = 3'd1,
    PH_POST  = 3'd2,
    PH_WAIT  = 3'd3,
    PH_COUNT = 3'd4,
    PH_IDLE  = 3'd5
  } phase_e;

  typedef struct packed {
    logic trig;
    logic fall;
    logic timeout;
  } seq_evt_t;

endpackage

[rtl/ultrasonic_echo_ranger.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger and echo-pulse ranging with a Q4 centimetre distance and near flag.
// ----------------------------------------------------------------------------
// Each input word is one sampled tick of the echo pin and yields exactly one
// result word, in order. The block takes one word per cycle while input ready
// is high, through its stages to the result register: the phase sequencer
// in the first stage, the count-by-scale multiply in the second, and rounding,
// saturation, the range check and the near compare in the third. Input ready
// drops only when every stage holds a word and the result is not being taken.
// Register writes take effect at once and need no setup after reset.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_WIDTH = uer_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uer_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [uer_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          echo_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trigger_out_o,
  output logic [uer_pkg::DistW-1:0]     distance_q4_o,
  output logic                          near_flag_o,
  output logic                          new_reading_o,
  output logic                          out_of_range_o
);

  localparam int unsigned ProdW = COUNT_WIDTH + uer_pkg::ScaleW;
  localparam int unsigned QW    = ProdW + 1 - uer_pkg::ProdShift;
  localparam logic [ProdW:0] RoundBias = (ProdW + 1)'(1) << (uer_pkg::ProdShift - 1);

  logic [15:0]                 pre_low_q, pulse_q, post_low_q;
  logic [23:0]                 interval_q, timeout_q;
  logic [uer_pkg::ScaleW-1:0]  scale_q;
  logic [uer_pkg::RangeW-1:0]  max_range_q, near_cm_q;

  logic                        ready1, ready2, in_acc, out_ld;
  uer_pkg::seq_evt_t           seq_evt;
  logic [COUNT_WIDTH-1:0]      seq_count;

  logic                        v1_q, v2_q, out_valid_q;
  uer_pkg::seq_evt_t           s1_evt_q, s2_evt_q;
  logic [COUNT_WIDTH-1:0]      s1_cnt_q;
  logic [ProdW-1:0]            s2_prod_q, s2_prod_d;

  logic [ProdW:0]              rnd_sum;
  logic [QW-1:0]               q_full;
  logic [uer_pkg::DistW-1:0]   dist_sat, dist_d, dist_q;
  logic                        reject, done, near_d, near_q;
  logic                        trig_q, newr_q, oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_low_q   <= uer_pkg::PreLowRst;
      pulse_q     <= uer_pkg::PulseRst;
      post_low_q  <= uer_pkg::PostLowRst;
      interval_q  <= uer_pkg::IntervalRst;
      timeout_q   <= uer_pkg::TimeoutRst;
      scale_q     <= uer_pkg::ScaleRst;
      max_range_q <= uer_pkg::MaxRangeRst;
      near_cm_q   <= uer_pkg::NearRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uer_pkg::CFG_PRE_LOW:  pre_low_q   <= cfg_data_i[15:0];
        uer_pkg::CFG_PULSE:    pulse_q     <= cfg_data_i[15:0];
        uer_pkg::CFG_POST_LOW: post_low_q  <= cfg_data_i[15:0];
        uer_pkg::CFG_INTERVAL: interval_q  <= cfg_data_i[23:0];
        uer_pkg::CFG_TIMEOUT:  timeout_q   <= cfg_data_i[23:0];
        uer_pkg::CFG_SCALE:    scale_q     <= cfg_data_i[uer_pkg::ScaleW-1:0];
        uer_pkg::CFG_MAX_RNG:  max_range_q <= cfg_data_i[uer_pkg::RangeW-1:0];
        uer_pkg::CFG_NEAR:     near_cm_q   <= cfg_data_i[uer_pkg::RangeW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ready2     = !v2_q || !out_valid_q || out_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;
  assign in_acc     = in_valid_i && ready1;
  assign out_ld     = v2_q && (!out_valid_q || out_ready_i);

  uer_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_acc),
    .echo_i     (echo_level_i),
    .pre_low_i  (pre_low_q),
    .pulse_i    (pulse_q),
    .post_low_i (post_low_q),
    .interval_i (interval_q),
    .timeout_i  (timeout_q),
    .evt_o      (seq_evt),
    .count_o    (seq_count)
  );

  assign s2_prod_d = ProdW'(s1_cnt_q) * ProdW'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_acc;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_evt_q <= seq_evt;
      s1_cnt_q <= seq_count;
    end
    if (v1_q && ready2) begin
      s2_evt_q  <= s1_evt_q;
      s2_prod_q <= s2_prod_d;
    end
    if (out_ld) begin
      trig_q <= s2_evt_q.trig;
      newr_q <= done;
      oor_q  <= s2_evt_q.timeout || (s2_evt_q.fall && reject);
    end
  end

  assign rnd_sum  = {1'b0, s2_prod_q} + RoundBias;
  assign q_full   = rnd_sum[ProdW:uer_pkg::ProdShift];
  assign dist_sat = (|q_full[QW-1:uer_pkg::DistW]) ? uer_pkg::DistMax
                                                    : q_full[uer_pkg::DistW-1:0];
  assign reject   = dist_sat > {max_range_q, {uer_pkg::FracBits{1'b0}}};
  assign done     = s2_evt_q.fall || s2_evt_q.timeout;
  assign dist_d   = (s2_evt_q.fall && !reject) ? dist_sat : dist_q;
  assign near_d   = done ? (dist_d < {near_cm_q, {uer_pkg::FracBits{1'b0}}}) : near_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
      near_q <= 1'b0;
    end else if (out_ld) begin
      dist_q <= dist_d;
      near_q <= near_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trigger_out_o  = trig_q;
  assign distance_q4_o  = dist_q;
  assign near_flag_o    = near_q;
  assign new_reading_o  = newr_q;
  assign out_of_range_o = oor_q;

endmodule

[rtl/uer_seq.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger sequencer
// Trigger and echo phase machine, advanced once for every accepted word.
// ----------------------------------------------------------------------------
module uer_seq #(
  parameter int unsigned COUNT_WIDTH = uer_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          echo_i,
  input  logic [15:0]                   pre_low_i,
  input  logic [15:0]                   pulse_i,
  input  logic [15:0]                   post_low_i,
  input  logic [23:0]                   interval_i,
  input  logic [23:0]                   timeout_i,
  output uer_pkg::seq_evt_t             evt_o,
  output logic [COUNT_WIDTH-1:0]        count_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  uer_pkg::phase_e                     phase_q, phase_d, skip_ph;
  logic [uer_pkg::PhaseCntW-1:0]       phase_count_q, phase_count_d, skip_pc, pc_inc;
  logic [COUNT_WIDTH-1:0]              echo_count_q, echo_count_d;

  function automatic logic timed(uer_pkg::phase_e ph);
    return (ph == uer_pkg::PH_PRE) || (ph == uer_pkg::PH_PULSE) ||
           (ph == uer_pkg::PH_POST) || (ph == uer_pkg::PH_IDLE);
  endfunction

  function automatic logic [uer_pkg::PhaseCntW-1:0] phase_len(uer_pkg::phase_e ph,
      logic [15:0] pre, logic [15:0] pulse, logic [15:0] post, logic [23:0] ival);
    logic [uer_pkg::PhaseCntW-1:0] len;
    case (ph)
      uer_pkg::PH_PRE:   len = uer_pkg::PhaseCntW'(pre);
      uer_pkg::PH_PULSE: len = uer_pkg::PhaseCntW'(pulse);
      uer_pkg::PH_POST:  len = uer_pkg::PhaseCntW'(post);
      default:           len = uer_pkg::PhaseCntW'(ival);
    endcase
    return len;
  endfunction

  function automatic uer_pkg::phase_e next_timed(uer_pkg::phase_e ph);
    uer_pkg::phase_e nx;
    case (ph)
      uer_pkg::PH_PRE:   nx = uer_pkg::PH_PULSE;
      uer_pkg::PH_PULSE: nx = uer_pkg::PH_POST;
      uer_pkg::PH_POST:  nx = uer_pkg::PH_WAIT;
      default:           nx = uer_pkg::PH_PRE;
    endcase
    return nx;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= uer_pkg::PH_PRE;
      phase_count_q <= '0;
      echo_count_q  <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      phase_count_q <= phase_count_d;
      echo_count_q  <= echo_count_d;
    end
  end

  // Timed phases that have run their length, zero-length ones included, are
  // passed through in the same tick; at most four can follow one another.
  always_comb begin
    skip_ph = phase_q;
    skip_pc = phase_count_q;
    for (int i = 0; i < 4; i++) begin
      if (timed(skip_ph) &&
          (skip_pc >= phase_len(skip_ph, pre_low_i, pulse_i, post_low_i, interval_i))) begin
        skip_ph = next_timed(skip_ph);
        skip_pc = '0;
      end
    end
  end

  assign pc_inc  = skip_pc + uer_pkg::PhaseCntW'(1);
  assign count_o = echo_count_q;

  always_comb begin
    phase_d       = skip_ph;
    phase_count_d = pc_inc;
    echo_count_d  = echo_count_q;
    evt_o         = '0;
    case (skip_ph)
      uer_pkg::PH_PRE, uer_pkg::PH_POST, uer_pkg::PH_IDLE: begin
        phase_count_d = pc_inc;
      end
      uer_pkg::PH_PULSE: begin
        evt_o.trig    = 1'b1;
        phase_count_d = pc_inc;
      end
      uer_pkg::PH_WAIT: begin
        if (echo_i) begin
          phase_d       = uer_pkg::PH_COUNT;
          phase_count_d = '0;
          echo_count_d  = COUNT_WIDTH'(1);
        end else if (pc_inc >= timeout_i) begin
          evt_o.timeout = 1'b1;
          phase_d       = uer_pkg::PH_IDLE;
          phase_count_d = '0;
          echo_count_d  = '0;
        end
      end
      uer_pkg::PH_COUNT: begin
        phase_count_d = skip_pc;
        if (echo_i) begin
          if (echo_count_q != CountMax) begin
            echo_count_d = echo_count_q + COUNT_WIDTH'(1);
          end
        end else begin
          evt_o.fall    = 1'b1;
          phase_d       = uer_pkg::PH_IDLE;
          phase_count_d = '0;
          echo_count_d  = '0;
        end
      end
      default: begin
        phase_d       = uer_pkg::PH_PRE;
        phase_count_d = '0;
      end
    endcase
  end

endmodule

[rtl/uer_checker.sv]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger checker
// Port-level properties of the ranger, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module uer_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          trigger_out_o,
  input logic [uer_pkg::DistW-1:0]     distance_q4_o,
  input logic                          near_flag_o,
  input logic                          new_reading_o,
  input logic                          out_of_range_o
);

  // A rejected measurement is always reported as a completed one.
  `UER_ASSERT_SAME(a_oor_needs_new, clk_i, rst_ni, out_valid_o && out_of_range_o, new_reading_o)

  // The trigger is driven only while no measurement can complete.
  `UER_ASSERT_SAME(a_trig_excl, clk_i, rst_ni, out_valid_o && trigger_out_o, !new_reading_o)

  // The distance moves only with an accepted reading.
  `UER_ASSERT_SAME(a_dist_change, clk_i, rst_ni, !$stable(distance_q4_o),
                   out_valid_o && new_reading_o && !out_of_range_o)

  // A result word waiting for its consumer stays presented.
  `UER_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(near_flag_o) && $stable(new_reading_o))

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .trigger_out_o  (trigger_out_o),
  .distance_q4_o  (distance_q4_o),
  .near_flag_o    (near_flag_o),
  .new_reading_o  (new_reading_o),
  .out_of_range_o (out_of_range_o)
);
